### sv/sdcr_pkg.sv
// Shared types, codes and constants of the SD card command responder.
`default_nettype none

package sdcr_pkg;

    // Card states, one-hot.
    typedef enum logic [6:0] {
        CS_IDLE        = 7'b0000001,
        CS_IDENT       = 7'b0000010,
        CS_STANDBY     = 7'b0000100,
        CS_TRANSFER    = 7'b0001000,
        CS_SENDING     = 7'b0010000,
        CS_RECEIVING   = 7'b0100000,
        CS_PROGRAMMING = 7'b1000000
    } card_state_t;

    // Kind of response selected by the decoder.
    typedef enum logic [2:0] {
        RK_NONE   = 3'd0,
        RK_STATUS = 3'd1,
        RK_CID    = 3'd2,
        RK_CSD    = 3'd3,
        RK_OCR    = 3'd4,
        RK_RCA    = 3'd5,
        RK_ECHO   = 3'd6
    } rsp_kind_t;

    // Command indexes.
    localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
    localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA     = 6'd3;
    localparam logic [5:0] CMD_SWITCH       = 6'd6;
    localparam logic [5:0] CMD_SELECT       = 6'd7;
    localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
    localparam logic [5:0] CMD_SEND_CID     = 6'd10;
    localparam logic [5:0] CMD_STOP         = 6'd12;
    localparam logic [5:0] CMD_SEND_STATUS  = 6'd13;
    localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
    localparam logic [5:0] CMD_READ_MULTI   = 6'd18;
    localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
    localparam logic [5:0] CMD_WRITE_MULTI  = 6'd25;
    localparam logic [5:0] CMD_ERASE_START  = 6'd32;
    localparam logic [5:0] CMD_ERASE_END    = 6'd33;
    localparam logic [5:0] CMD_ERASE        = 6'd38;
    localparam logic [5:0] CMD_APP          = 6'd55;
    localparam logic [5:0] ACMD_BUS_WIDTH   = 6'd6;
    localparam logic [5:0] ACMD_OP_COND     = 6'd41;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RCA           = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARD_SIZE     = 2'd2;

    // Transfer kinds.
    localparam logic [1:0] XFER_NONE  = 2'd0;
    localparam logic [1:0] XFER_READ  = 2'd1;
    localparam logic [1:0] XFER_WRITE = 2'd2;

    // Response lengths in bytes.
    localparam logic [4:0] LEN_NONE  = 5'd0;
    localparam logic [4:0] LEN_SHORT = 5'd4;
    localparam logic [4:0] LEN_LONG  = 5'd16;

    // Status, OCR, CID and CSD contents.
    localparam int unsigned STATUS_APP_CMD_BIT = 5;
    localparam int unsigned STATUS_READY_BIT   = 8;
    localparam logic [31:0] OCR_BUSY   = 32'h8000_0000;
    localparam logic [31:0] OCR_CCS    = 32'h4000_0000;
    localparam logic [31:0] CID_WORD0  = 32'h0000_018C;
    localparam logic [31:0] CID_WORD1  = 32'h7500_0000;
    localparam logic [31:0] CID_WORD2  = 32'h6D38_656D;
    localparam logic [31:0] CSD_WORD0  = 32'h0002_4000;
    localparam logic [31:0] CSD_WORD2  = 32'h3200_0900;
    localparam logic [31:0] CSD_WORD3  = 32'h0040_0000;
    localparam int unsigned BLOCK_SHIFT = 9;

    typedef struct packed {
        logic        high_capacity;
        logic [15:0] relative_card_address;
        logic [21:0] card_size;
    } cfg_t;

    typedef struct packed {
        card_state_t card_state;
        logic        waiting_app_command;
        logic [31:0] check_pattern;
    } card_ctx_t;

    typedef struct packed {
        logic [4:0]  response_bytes;
        logic [31:0] resp_word0;
        logic [31:0] resp_word1;
        logic [31:0] resp_word2;
        logic [31:0] resp_word3;
        logic [1:0]  transfer_kind;
        logic [40:0] data_offset;
    } result_t;

endpackage

`default_nettype wire

### sv/sdcr_if.sv
// Handshake channel interfaces: command requests, responses and configuration writes.
`default_nettype none

interface sdcr_cmd_if;
    logic        valid;
    logic        ready;
    logic [5:0]  command;
    logic [31:0] argument;

    modport source (output valid, output command, output argument, input ready);
    modport sink (input valid, input command, input argument, output ready);
endinterface

interface sdcr_rsp_if;
    logic        valid;
    logic        ready;
    logic [4:0]  response_bytes;
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
    logic [1:0]  transfer_kind;
    logic [40:0] data_offset;

    modport source (output valid, output response_bytes, output resp_word0,
                    output resp_word1, output resp_word2, output resp_word3,
                    output transfer_kind, output data_offset, input ready);
    modport sink (input valid, input response_bytes, input resp_word0,
                  input resp_word1, input resp_word2, input resp_word3,
                  input transfer_kind, input data_offset, output ready);
endinterface

interface sdcr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sdcr_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/sd_card_command_responder.sv
// Top level of the SD card command responder: request register, decoder and response register.
//
// The host side pushes command requests (command index and 32-bit argument) on
// the cmd channel; each accepted request yields exactly one response on the
// rsp channel, in order. The response carries the response length (0, 4 or
// 16 bytes), four response words, the data transfer kind and the byte offset
// of a data command. The cfg channel writes the high capacity flag, the
// relative card address and the card size; it is always ready and should
// only be written while no request is in flight.
// An accepted request is held in the request register while the decoder feeds
// the response register, from which the response is offered on rsp.
// Throughput is one request per cycle while the receiver does not stall; the
// card state, the CMD55 flag and the CMD8 check pattern are updated in the
// same cycle a request moves into the response register, so back-to-back
// requests see each other's effects.
// When the receiver stalls, the response register holds its contents and the
// request register fills; cmd.ready drops only when both are occupied and
// rsp.ready is low. Reset clears both valid flags, returns the card to idle,
// clears the CMD55 flag and check pattern, and restores the configuration.
`default_nettype none

module sd_card_command_responder (
    input  wire logic clk,
    input  wire logic rst_n,
    sdcr_cmd_if.sink  cmd,
    sdcr_rsp_if.source rsp,
    sdcr_cfg_if.sink  cfg
);

    // Configuration values, held in their own register file.
    sdcr_pkg::cfg_t cfg_val;

    // Request register: one command waiting to be decoded.
    logic        req_valid_reg;
    logic [5:0]  req_command_reg;
    logic [31:0] req_argument_reg;

    // Card context carried from one request to the next.
    sdcr_pkg::card_ctx_t ctx_reg;
    sdcr_pkg::card_ctx_t ctx_next;

    // Response register.
    logic              rsp_valid_reg;
    sdcr_pkg::result_t rsp_reg;
    sdcr_pkg::result_t rsp_next;

    logic advance;

    sdcr_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    sdcr_decode u_decode (
        .command  (req_command_reg),
        .argument (req_argument_reg),
        .cfg_val  (cfg_val),
        .ctx      (ctx_reg),
        .ctx_next (ctx_next),
        .result   (rsp_next)
    );

    // The decoded request moves on whenever the response register is free
    // or is being emptied in this cycle.
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign cmd.ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            req_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            req_command_reg  <= cmd.command;
            req_argument_reg <= cmd.argument;
        end
    end

    // Context commits exactly once per request, when its response is stored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.card_state          <= sdcr_pkg::CS_IDLE;
            ctx_reg.waiting_app_command <= 1'b0;
            ctx_reg.check_pattern       <= '0;
        end
        else if (advance)
        begin
            ctx_reg <= ctx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.response_bytes = rsp_reg.response_bytes;
    assign rsp.resp_word0     = rsp_reg.resp_word0;
    assign rsp.resp_word1     = rsp_reg.resp_word1;
    assign rsp.resp_word2     = rsp_reg.resp_word2;
    assign rsp.resp_word3     = rsp_reg.resp_word3;
    assign rsp.transfer_kind  = rsp_reg.transfer_kind;
    assign rsp.data_offset    = rsp_reg.data_offset;

endmodule

`default_nettype wire

### sv/sdcr_cfg_regs.sv
// Configuration register file of the SD card command responder.
`default_nettype none

module sdcr_cfg_regs (
    input  wire logic             clk,
    input  wire logic             rst_n,
    sdcr_cfg_if.sink              cfg,
    output sdcr_pkg::cfg_t        cfg_val
);

    sdcr_pkg::cfg_t cfg_reg;

    // Writes are always taken; an index past the last register is dropped.
    assign cfg.ready = 1'b1;
    assign cfg_val   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_capacity         <= 1'b1;
            cfg_reg.relative_card_address <= '0;
            cfg_reg.card_size             <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sdcr_pkg::CFG_HIGH_CAPACITY: cfg_reg.high_capacity <= cfg.data[0];
                sdcr_pkg::CFG_RCA:           cfg_reg.relative_card_address <= cfg.data[15:0];
                sdcr_pkg::CFG_CARD_SIZE:     cfg_reg.card_size <= cfg.data[21:0];
                default:                     ;
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/sdcr_decode.sv
// Command decoder: next card context and response contents for one command.
`default_nettype none

module sdcr_decode (
    input  wire logic [5:0]          command,
    input  wire logic [31:0]         argument,
    input  wire sdcr_pkg::cfg_t      cfg_val,
    input  wire sdcr_pkg::card_ctx_t ctx,
    output sdcr_pkg::card_ctx_t      ctx_next,
    output sdcr_pkg::result_t        result
);

    sdcr_pkg::rsp_kind_t kind;
    logic [1:0]          xfer;
    logic [40:0]         full_offset;

    // Block addressing scales the argument by the 512-byte block size.
    assign full_offset = cfg_val.high_capacity
                       ? {argument, {sdcr_pkg::BLOCK_SHIFT{1'b0}}}
                       : {{sdcr_pkg::BLOCK_SHIFT{1'b0}}, argument};

    always_comb
    begin
        ctx_next = ctx;
        kind     = sdcr_pkg::RK_NONE;
        xfer     = sdcr_pkg::XFER_NONE;
        if (ctx.waiting_app_command)
        begin
            // The flag is consumed by whatever command follows CMD55.
            ctx_next.waiting_app_command = 1'b0;
            case (command)
                sdcr_pkg::ACMD_BUS_WIDTH: kind = sdcr_pkg::RK_STATUS;
                sdcr_pkg::ACMD_OP_COND:   kind = sdcr_pkg::RK_OCR;
                default:                  kind = sdcr_pkg::RK_NONE;
            endcase
        end
        else
        begin
            case (command)
                sdcr_pkg::CMD_GO_IDLE:
                begin
                    ctx_next.card_state = sdcr_pkg::CS_IDLE;
                end
                sdcr_pkg::CMD_ALL_SEND_CID:
                begin
                    ctx_next.card_state = sdcr_pkg::CS_IDENT;
                    kind = sdcr_pkg::RK_CID;
                end
                sdcr_pkg::CMD_SEND_RCA:
                begin
                    ctx_next.card_state = sdcr_pkg::CS_STANDBY;
                    kind = sdcr_pkg::RK_RCA;
                end
                sdcr_pkg::CMD_SELECT:
                begin
                    if (ctx.card_state == sdcr_pkg::CS_STANDBY)
                        ctx_next.card_state = sdcr_pkg::CS_TRANSFER;
                    else if (ctx.card_state == sdcr_pkg::CS_TRANSFER ||
                             ctx.card_state == sdcr_pkg::CS_PROGRAMMING)
                        ctx_next.card_state = sdcr_pkg::CS_STANDBY;
                    kind = sdcr_pkg::RK_STATUS;
                end
                sdcr_pkg::CMD_SEND_IF_COND:
                begin
                    ctx_next.check_pattern = argument;
                    kind = sdcr_pkg::RK_ECHO;
                end
                sdcr_pkg::CMD_SEND_CSD: kind = sdcr_pkg::RK_CSD;
                sdcr_pkg::CMD_SEND_CID: kind = sdcr_pkg::RK_CID;
                sdcr_pkg::CMD_STOP:
                begin
                    if (ctx.card_state == sdcr_pkg::CS_SENDING)
                        ctx_next.card_state = sdcr_pkg::CS_TRANSFER;
                    else if (ctx.card_state == sdcr_pkg::CS_RECEIVING)
                        ctx_next.card_state = sdcr_pkg::CS_PROGRAMMING;
                    kind = sdcr_pkg::RK_STATUS;
                end
                sdcr_pkg::CMD_READ_SINGLE, sdcr_pkg::CMD_READ_MULTI:
                begin
                    if (ctx.card_state == sdcr_pkg::CS_TRANSFER)
                        ctx_next.card_state = sdcr_pkg::CS_SENDING;
                    xfer = sdcr_pkg::XFER_READ;
                    kind = sdcr_pkg::RK_STATUS;
                end
                sdcr_pkg::CMD_WRITE_SINGLE, sdcr_pkg::CMD_WRITE_MULTI:
                begin
                    if (ctx.card_state == sdcr_pkg::CS_TRANSFER)
                        ctx_next.card_state = sdcr_pkg::CS_RECEIVING;
                    xfer = sdcr_pkg::XFER_WRITE;
                    kind = sdcr_pkg::RK_STATUS;
                end
                sdcr_pkg::CMD_SWITCH, sdcr_pkg::CMD_SEND_STATUS,
                sdcr_pkg::CMD_ERASE_START, sdcr_pkg::CMD_ERASE_END,
                sdcr_pkg::CMD_ERASE:
                begin
                    kind = sdcr_pkg::RK_STATUS;
                end
                sdcr_pkg::CMD_APP:
                begin
                    ctx_next.waiting_app_command = 1'b1;
                    kind = sdcr_pkg::RK_STATUS;
                end
                default: kind = sdcr_pkg::RK_NONE;
            endcase
        end
    end

    always_comb
    begin
        result = '0;
        result.transfer_kind = xfer;
        result.data_offset   = (xfer != sdcr_pkg::XFER_NONE) ? full_offset : '0;
        case (kind)
            sdcr_pkg::RK_STATUS:
            begin
                // APP_CMD reflects the flag as it stands after this command.
                result.response_bytes = sdcr_pkg::LEN_SHORT;
                result.resp_word0[sdcr_pkg::STATUS_READY_BIT]   = 1'b1;
                result.resp_word0[sdcr_pkg::STATUS_APP_CMD_BIT] =
                    ctx_next.waiting_app_command;
            end
            sdcr_pkg::RK_CID:
            begin
                result.response_bytes = sdcr_pkg::LEN_LONG;
                result.resp_word0 = sdcr_pkg::CID_WORD0;
                result.resp_word1 = sdcr_pkg::CID_WORD1;
                result.resp_word2 = sdcr_pkg::CID_WORD2;
            end
            sdcr_pkg::RK_CSD:
            begin
                result.response_bytes = sdcr_pkg::LEN_LONG;
                if (cfg_val.high_capacity)
                begin
                    result.resp_word0 = sdcr_pkg::CSD_WORD0;
                    result.resp_word1 = {2'b00, cfg_val.card_size, 8'h00};
                    result.resp_word2 = sdcr_pkg::CSD_WORD2;
                    result.resp_word3 = sdcr_pkg::CSD_WORD3;
                end
            end
            sdcr_pkg::RK_OCR:
            begin
                result.response_bytes = sdcr_pkg::LEN_SHORT;
                result.resp_word0 = sdcr_pkg::OCR_BUSY
                                  | (cfg_val.high_capacity ? sdcr_pkg::OCR_CCS : 32'h0);
            end
            sdcr_pkg::RK_RCA:
            begin
                result.response_bytes = sdcr_pkg::LEN_SHORT;
                result.resp_word0 = {16'h0000, cfg_val.relative_card_address};
            end
            sdcr_pkg::RK_ECHO:
            begin
                result.response_bytes = sdcr_pkg::LEN_SHORT;
                result.resp_word0 = ctx_next.check_pattern;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the SD card command responder: random command traffic against a predictor.
`timescale 1ns / 1ps

module tb;
    import sdcr_pkg::*;

    // Run limits and receiver behavior.
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    localparam int RX_ALWAYS   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    // Register index that the block does not decode; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [5:0]  command;
        logic [31:0] argument;
    } host_cmd_t;

    logic clk;
    logic rst_n;

    sdcr_cmd_if cmd_ch ();
    sdcr_rsp_if rsp_ch ();
    sdcr_cfg_if cfg_ch ();

    sd_card_command_responder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Requests waiting to be offered, and responses the card owes us, oldest first.
    host_cmd_t pending_requests[$];
    result_t   expected_responses[$];

    // Predicted card context and configuration.
    cfg_t        model_cfg;
    card_state_t model_state;
    logic        model_app_armed;
    logic [31:0] model_pattern;

    // Knobs that the stimulus sequence changes between phases, while the block is idle.
    int gap_max;
    int rx_mode;
    int stall_token;

    int error_count;
    int mismatch_count;
    int response_count;
    int cycle_count;

    // Sender and receiver private state.
    int        burst_left;
    int        gap_left;
    bit        request_taken;
    host_cmd_t next_request;
    int        rx_tick;
    int        stall_seen;
    int        long_stall_left;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Works out the response to one host command and advances the predicted card context.
    // The application flag is consumed before decoding, so the status word of an
    // application command reports APP_CMD clear, while CMD55 itself reports it set.
    function automatic result_t predict_response(input logic [5:0] idx, input logic [31:0] arg);
        rsp_kind_t kind;
        result_t   r;
        kind = RK_NONE;
        r = '0;
        if (model_app_armed)
        begin
            model_app_armed = 1'b0;
            case (idx)
                ACMD_BUS_WIDTH: kind = RK_STATUS;
                ACMD_OP_COND:   kind = RK_OCR;
                default:        kind = RK_NONE;
            endcase
        end
        else
        begin
            case (idx)
                CMD_GO_IDLE:
                    model_state = CS_IDLE;
                CMD_ALL_SEND_CID:
                begin
                    model_state = CS_IDENT;
                    kind = RK_CID;
                end
                CMD_SEND_RCA:
                begin
                    model_state = CS_STANDBY;
                    kind = RK_RCA;
                end
                CMD_SELECT:
                begin
                    if (model_state == CS_STANDBY)
                        model_state = CS_TRANSFER;
                    else if (model_state == CS_TRANSFER || model_state == CS_PROGRAMMING)
                        model_state = CS_STANDBY;
                    kind = RK_STATUS;
                end
                CMD_SEND_IF_COND:
                begin
                    model_pattern = arg;
                    kind = RK_ECHO;
                end
                CMD_SEND_CSD:
                    kind = RK_CSD;
                CMD_SEND_CID:
                    kind = RK_CID;
                CMD_STOP:
                begin
                    if (model_state == CS_SENDING)
                        model_state = CS_TRANSFER;
                    else if (model_state == CS_RECEIVING)
                        model_state = CS_PROGRAMMING;
                    kind = RK_STATUS;
                end
                CMD_READ_SINGLE, CMD_READ_MULTI:
                begin
                    if (model_state == CS_TRANSFER)
                        model_state = CS_SENDING;
                    r.transfer_kind = XFER_READ;
                    r.data_offset = model_cfg.high_capacity ? {arg, 9'd0} : {9'd0, arg};
                    kind = RK_STATUS;
                end
                CMD_WRITE_SINGLE, CMD_WRITE_MULTI:
                begin
                    if (model_state == CS_TRANSFER)
                        model_state = CS_RECEIVING;
                    r.transfer_kind = XFER_WRITE;
                    r.data_offset = model_cfg.high_capacity ? {arg, 9'd0} : {9'd0, arg};
                    kind = RK_STATUS;
                end
                CMD_SWITCH, CMD_SEND_STATUS, CMD_ERASE_START, CMD_ERASE_END, CMD_ERASE:
                    kind = RK_STATUS;
                CMD_APP:
                begin
                    model_app_armed = 1'b1;
                    kind = RK_STATUS;
                end
                default:
                    kind = RK_NONE;
            endcase
        end

        case (kind)
            RK_STATUS:
            begin
                r.response_bytes = 5'd4;
                r.resp_word0 = (32'(model_app_armed) << 5) | (32'd1 << 8);
            end
            RK_CID:
            begin
                r.response_bytes = 5'd16;
                r.resp_word0 = 32'h0000_018C;
                r.resp_word1 = 32'h75 << 24;
                r.resp_word2 = 32'h6D38_656D;
            end
            RK_CSD:
            begin
                // A standard capacity card reports an all-zero CSD.
                r.response_bytes = 5'd16;
                if (model_cfg.high_capacity)
                begin
                    r.resp_word0 = 32'd9 << 14;
                    r.resp_word1 = {2'b00, model_cfg.card_size, 8'h00};
                    r.resp_word2 = (32'h32 << 24) | (32'd9 << 8);
                    r.resp_word3 = 32'd1 << 22;
                end
            end
            RK_OCR:
            begin
                r.response_bytes = 5'd4;
                r.resp_word0 = 32'h8000_0000 | (model_cfg.high_capacity ? 32'h4000_0000 : 32'h0);
            end
            RK_RCA:
            begin
                r.response_bytes = 5'd4;
                r.resp_word0 = {16'h0000, model_cfg.relative_card_address};
            end
            RK_ECHO:
            begin
                r.response_bytes = 5'd4;
                r.resp_word0 = model_pattern;
            end
            default:
                r.response_bytes = 5'd0;
        endcase
        return r;
    endfunction

    // Sender: offers requests from the pending queue in bursts separated by random gaps.
    // A request stays on the bus unchanged until the block accepts it.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.command <= '0;
            cmd_ch.argument <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            request_taken = cmd_ch.valid && cmd_ch.ready;
            if (request_taken)
            begin
                expected_responses.push_back(predict_response(cmd_ch.command, cmd_ch.argument));
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0 && gap_max != 0)
                    gap_left = $urandom_range(1, gap_max);
            end

            if (cmd_ch.valid && !request_taken)
            begin
                // Request still waiting for ready: hold it.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                next_request = pending_requests.pop_front();
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 12);
                cmd_ch.valid <= 1'b1;
                cmd_ch.command <= next_request.command;
                cmd_ch.argument <= next_request.argument;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // Receiver: ready follows the phase's pattern, except during a long hold-off that
    // the stimulus asks for by bumping stall_token. The hold-off is timed here, so the
    // block backs up and drops cmd ready while the sender keeps offering.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_tick = 0;
            stall_seen = 0;
            long_stall_left = 0;
        end
        else
        begin
            rx_tick++;
            if (stall_token != stall_seen)
            begin
                stall_seen = stall_token;
                long_stall_left = LONG_STALL_CYCLES;
            end
            if (long_stall_left > 0)
            begin
                long_stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_RANDOM:   rsp_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: rsp_ch.ready <= ((rx_tick % 7) < 3);
                    default:     rsp_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // Monitor: every accepted response must match the oldest expectation, field by field.
    always @(posedge clk)
    begin : response_check
        result_t got;
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = {rsp_ch.response_bytes, rsp_ch.resp_word0, rsp_ch.resp_word1,
                   rsp_ch.resp_word2, rsp_ch.resp_word3, rsp_ch.transfer_kind,
                   rsp_ch.data_offset};
            if (expected_responses.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("response %0d arrived with no request outstanding: len=%0d w0=%h",
                             response_count, got.response_bytes, got.resp_word0);
            end
            else
            begin
                want = expected_responses.pop_front();
                if (got.response_bytes !== want.response_bytes
                    || got.resp_word0 !== want.resp_word0
                    || got.resp_word1 !== want.resp_word1
                    || got.resp_word2 !== want.resp_word2
                    || got.resp_word3 !== want.resp_word3
                    || got.transfer_kind !== want.transfer_kind
                    || got.data_offset !== want.data_offset)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("response %0d mismatch", response_count);
                        $display("  expected len=%0d w=%h %h %h %h kind=%0d off=%h",
                                 want.response_bytes, want.resp_word3, want.resp_word2,
                                 want.resp_word1, want.resp_word0, want.transfer_kind,
                                 want.data_offset);
                        $display("  actual   len=%0d w=%h %h %h %h kind=%0d off=%h",
                                 got.response_bytes, got.resp_word3, got.resp_word2,
                                 got.resp_word1, got.resp_word0, got.transfer_kind,
                                 got.data_offset);
                    end
                end
            end
            response_count++;
        end
    end

    // Writes one configuration register and mirrors it into the predictor on the handshake.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_HIGH_CAPACITY: model_cfg.high_capacity = value[0];
            CFG_RCA:           model_cfg.relative_card_address = value[15:0];
            CFG_CARD_SIZE:     model_cfg.card_size = value[21:0];
            default:           ;
        endcase
    endtask

    // Waits until every request has been sent and answered, then lets the
    // two-stage pipeline settle.
    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || cmd_ch.valid || expected_responses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic enqueue(input logic [5:0] idx, input logic [31:0] arg);
        host_cmd_t item;
        item.command = idx;
        item.argument = arg;
        pending_requests.push_back(item);
    endtask

    // Arguments lean toward the corners so that the offset multiply sees its extremes.
    function automatic logic [31:0] pick_argument();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(0, 255));
            3:       return 32'h8000_0000 | $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [5:0] pick_normal_command();
        case ($urandom_range(0, 17))
            0:       return CMD_GO_IDLE;
            1:       return CMD_ALL_SEND_CID;
            2:       return CMD_SEND_RCA;
            3:       return CMD_SWITCH;
            4:       return CMD_SELECT;
            5:       return CMD_SEND_IF_COND;
            6:       return CMD_SEND_CSD;
            7:       return CMD_SEND_CID;
            8:       return CMD_STOP;
            9:       return CMD_SEND_STATUS;
            10:      return CMD_READ_SINGLE;
            11:      return CMD_READ_MULTI;
            12:      return CMD_WRITE_SINGLE;
            13:      return CMD_WRITE_MULTI;
            14:      return CMD_ERASE_START;
            15:      return CMD_ERASE_END;
            16:      return CMD_ERASE;
            default: return CMD_APP;
        endcase
    endfunction

    function automatic logic [5:0] pick_data_command();
        case ($urandom_range(0, 3))
            0:       return CMD_READ_SINGLE;
            1:       return CMD_READ_MULTI;
            2:       return CMD_WRITE_SINGLE;
            default: return CMD_WRITE_MULTI;
        endcase
    endfunction

    // Fills the pending queue with about n requests. Most of them form the usual host
    // flows (bring-up, application commands, selected data transfers with a stop);
    // the rest are single commands, some of them any of the 64 indexes.
    task automatic queue_traffic(input int n);
        int start;
        start = pending_requests.size();
        while (pending_requests.size() - start < n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    enqueue(pick_normal_command(), pick_argument());
                3, 4:
                begin
                    enqueue(CMD_APP, pick_argument());
                    case ($urandom_range(0, 4))
                        0, 1:    enqueue(ACMD_OP_COND, pick_argument());
                        2:       enqueue(ACMD_BUS_WIDTH, pick_argument());
                        3:       enqueue(CMD_APP, pick_argument());
                        default: enqueue(6'($urandom_range(0, 63)), pick_argument());
                    endcase
                end
                5, 6, 7:
                begin
                    if ($urandom_range(0, 1))
                        enqueue(CMD_SELECT, pick_argument());
                    enqueue(pick_data_command(), pick_argument());
                    if ($urandom_range(0, 1))
                        enqueue(CMD_SEND_STATUS, pick_argument());
                    enqueue(CMD_STOP, pick_argument());
                    if ($urandom_range(0, 2) == 0)
                        enqueue(CMD_SELECT, pick_argument());
                end
                8:
                begin
                    enqueue(CMD_GO_IDLE, 32'h0);
                    enqueue(CMD_SEND_IF_COND, $urandom());
                    enqueue(CMD_APP, 32'h0);
                    enqueue(ACMD_OP_COND, pick_argument());
                    enqueue(CMD_ALL_SEND_CID, pick_argument());
                    enqueue(CMD_SEND_RCA, pick_argument());
                    enqueue(CMD_SEND_CSD, pick_argument());
                    enqueue(CMD_SELECT, pick_argument());
                end
                default:
                    enqueue(6'($urandom_range(0, 63)), pick_argument());
            endcase
        end
    endtask

    // One phase: program all registers (with junk above each field to check masking),
    // set the traffic shape, optionally ask for a long receiver hold-off, run, drain.
    task automatic run_phase(input logic hc, input logic [15:0] rca_value,
                             input logic [21:0] size_value, input int n, input int gap,
                             input int mode, input bit with_stall);
        write_register(CFG_HIGH_CAPACITY, ($urandom() & 32'hFFFF_FFFE) | 32'(hc));
        write_register(CFG_RCA, ($urandom() & 32'hFFFF_0000) | 32'(rca_value));
        write_register(CFG_CARD_SIZE, ($urandom() & 32'hFFC0_0000) | 32'(size_value));
        @(negedge clk);
        gap_max = gap;
        rx_mode = mode;
        if (with_stall)
            stall_token++;
        queue_traffic(n);
        wait_until_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.argument = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        model_cfg.high_capacity = 1'b1;
        model_cfg.relative_card_address = '0;
        model_cfg.card_size = '0;
        model_state = CS_IDLE;
        model_app_armed = 1'b0;
        model_pattern = '0;
        gap_max = 2;
        rx_mode = RX_RANDOM;
        stall_token = 0;
        error_count = 0;
        mismatch_count = 0;
        response_count = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, at reset configuration. Covers the application-command
        // corner cases (double CMD55, unknown command after CMD55, APP_CMD in the
        // status), an unknown normal command, the echo, the full state walk
        // including out-of-order stops and data commands, and extreme offsets.
        enqueue(CMD_SEND_STATUS, 32'h0);
        enqueue(CMD_SEND_CSD, 32'h0);
        enqueue(ACMD_OP_COND, 32'hFFFF_FFFF);
        enqueue(CMD_APP, 32'h0);
        enqueue(ACMD_OP_COND, 32'h4000_0000);
        enqueue(CMD_APP, 32'hFFFF_FFFF);
        enqueue(ACMD_BUS_WIDTH, 32'h2);
        enqueue(CMD_APP, 32'h0);
        enqueue(CMD_APP, 32'h0);
        enqueue(CMD_SEND_STATUS, 32'h0);
        enqueue(CMD_APP, 32'h0);
        enqueue(CMD_READ_SINGLE, 32'hFFFF_FFFF);
        enqueue(CMD_SEND_IF_COND, 32'hFFFF_FFFF);
        enqueue(CMD_SEND_IF_COND, 32'h0000_01AA);
        enqueue(CMD_GO_IDLE, 32'h0);
        enqueue(CMD_ALL_SEND_CID, 32'h0);
        enqueue(CMD_SEND_RCA, 32'h0);
        enqueue(CMD_SELECT, 32'h0);
        enqueue(CMD_READ_MULTI, 32'hFFFF_FFFF);
        enqueue(CMD_STOP, 32'h0);
        enqueue(CMD_WRITE_SINGLE, 32'h0);
        enqueue(CMD_READ_SINGLE, 32'h1);
        enqueue(CMD_STOP, 32'h0);
        enqueue(CMD_SELECT, 32'h0);
        enqueue(CMD_WRITE_MULTI, 32'hFFFF_FFFF);
        enqueue(CMD_SEND_CID, 32'h0);
        enqueue(CMD_ERASE, 32'h0);
        enqueue(6'd63, 32'hFFFF_FFFF);
        wait_until_drained();

        // A write to an undecoded index must leave every register alone.
        write_register(CFG_UNUSED, 32'hFFFF_FFFF);

        // Phases with different settings, extremes first. The first, fourth and sixth keep
        // the sender busy while the receiver holds off for a long stretch; every phase
        // ends with the sender paused until all responses are back.
        run_phase(1'b0, 16'hFFFF, 22'h3F_FFFF, 250, 0, RX_ALWAYS, 1'b1);
        run_phase(1'b1, 16'hFFFF, 22'h3F_FFFF, 250, 6, RX_RANDOM, 1'b0);
        run_phase(1'b1, 16'h0000, 22'h00_0000, 250, 3, RX_PERIODIC, 1'b0);
        run_phase(1'b0, 16'h0000, 22'h00_0000, 250, 10, RX_SPARSE, 1'b1);
        run_phase(1'($urandom_range(0, 1)), 16'($urandom()), 22'($urandom()), 275, 4,
                  RX_RANDOM, 1'b0);
        run_phase(1'b1, 16'($urandom()), 22'($urandom()), 275, 0, RX_PERIODIC, 1'b1);

        // Give a stray late response a chance to show up before judging.
        repeat (20) @(posedge clk);
        if (expected_responses.size() != 0)
            error_count++;

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, expected_responses.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
sv/sdcr_pkg.sv
sv/sdcr_if.sv
sv/sdcr_cfg_regs.sv
sv/sdcr_decode.sv
sv/sd_card_command_responder.sv
sim/tb.sv
